// ===== design/assert_macros.svh =====
// assertion macros used by the checker file iqz_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked while out of reset
`define ASSERT_ON(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/iqz_pkg.sv =====
package iqz_pkg;

    localparam int ANG_W = 27;

    typedef enum logic [1:0] {
        REG_Z_SCALE       = 2'd0,
        REG_CAL_INTERCEPT = 2'd1,
        REG_CAL_INV_SLOPE = 2'd2,
        REG_SAT_THRESHOLD = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic vld;
        logic zero;
        logic sat;
    } t_ctl;

    localparam logic signed [ANG_W-1:0] ANG_180 = 27'sd11796480;
    localparam logic [23:0] Z_SCALE_RST       = 24'd1048576;
    localparam logic [25:0] CAL_INTERCEPT_RST = 26'd0;
    localparam logic [19:0] CAL_INV_SLOPE_RST = 20'd65536;
    localparam logic [18:0] SAT_THRESHOLD_RST = 19'd507900;
    localparam logic [24:0] ZM_MAX = 25'h1FFFFFF;
    localparam logic signed [16:0] PH_LIM = 17'sd46080;

    // atan(2^-k) in 2^-16 degree
    function automatic logic signed [ANG_W-1:0] atan_val(input logic [4:0] k);
        logic signed [ANG_W-1:0] v;
        unique case (k)
            5'd0:  v = 27'sd2949120;
            5'd1:  v = 27'sd1740967;
            5'd2:  v = 27'sd919879;
            5'd3:  v = 27'sd466945;
            5'd4:  v = 27'sd234379;
            5'd5:  v = 27'sd117304;
            5'd6:  v = 27'sd58666;
            5'd7:  v = 27'sd29335;
            5'd8:  v = 27'sd14668;
            5'd9:  v = 27'sd7334;
            5'd10: v = 27'sd3667;
            5'd11: v = 27'sd1833;
            5'd12: v = 27'sd917;
            5'd13: v = 27'sd458;
            5'd14: v = 27'sd229;
            5'd15: v = 27'sd115;
            5'd16: v = 27'sd57;
            5'd17: v = 27'sd29;
            5'd18: v = 27'sd14;
            5'd19: v = 27'sd7;
            5'd20: v = 27'sd4;
            5'd21: v = 27'sd2;
            5'd22: v = 27'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/iqz_stage.sv =====
module iqz_stage #(
    parameter int W         = 20,
    parameter int XW        = 30,
    parameter int K         = 0,
    parameter int J         = 19,
    parameter bit DO_SQRT   = 1'b1,
    parameter bit DO_CORDIC = 1'b1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  iqz_pkg::t_ctl               i_ctl,
    input  logic [2*W-1:0]              i_rem,
    input  logic [W-1:0]                i_root,
    input  logic signed [XW-1:0]        i_x,
    input  logic signed [XW-1:0]        i_y,
    input  logic signed [iqz_pkg::ANG_W-1:0] i_ang,
    output iqz_pkg::t_ctl               o_ctl,
    output logic [2*W-1:0]              o_rem,
    output logic [W-1:0]                o_root,
    output logic signed [XW-1:0]        o_x,
    output logic signed [XW-1:0]        o_y,
    output logic signed [iqz_pkg::ANG_W-1:0] o_ang
);
    import iqz_pkg::*;

    localparam int TW = 2*W+2;

    logic [2*W-1:0]              n_rem;
    logic [W-1:0]                n_root;
    logic signed [XW-1:0]        n_x, n_y;
    logic signed [ANG_W-1:0]     n_ang;

    generate
        if (DO_SQRT) begin : g_sqrt
            logic [TW-1:0] w_test;
            always_comb begin
                w_test = ((TW'(i_root) << 1) + (TW'(1) << J)) << J;
                if (TW'(i_rem) >= w_test) begin
                    n_rem  = i_rem - w_test[2*W-1:0];
                    n_root = i_root | (W'(1) << J);
                end else begin
                    n_rem  = i_rem;
                    n_root = i_root;
                end
            end
        end else begin : g_nosqrt
            assign n_rem  = i_rem;
            assign n_root = i_root;
        end

        if (DO_CORDIC) begin : g_cordic
            logic signed [XW-1:0] w_dx, w_dy;
            always_comb begin
                w_dx = i_y >>> K;
                w_dy = i_x >>> K;
                if (i_y > 0) begin
                    n_x   = i_x + w_dx;
                    n_y   = i_y - w_dy;
                    n_ang = i_ang + atan_val(5'(K));
                end else begin
                    n_x   = i_x - w_dx;
                    n_y   = i_y + w_dy;
                    n_ang = i_ang - atan_val(5'(K));
                end
            end
        end else begin : g_nocordic
            assign n_x   = i_x;
            assign n_y   = i_y;
            assign n_ang = i_ang;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.vld <= 1'b0;
        end else if (i_en) begin
            o_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_rem;
            o_root <= n_root;
            o_x    <= n_x;
            o_y    <= n_y;
            o_ang  <= n_ang;
        end
    end

endmodule

// ===== design/iq_to_impedance_phase_top.sv =====
// pipeline: input word through registers r1 to r3, then the square root and cordic stages
// (one square root bit and one cordic step per stage), then p1 to p4 and r5 to the output word
// throughput: one word per cycle; the whole pipe stalls only while an output word waits
// reset: synchronous active low, clears all valid bits and loads the register defaults
module iq_to_impedance_phase_top #(
    parameter int SAMPLE_BITS   = 20,
    parameter int CORDIC_STAGES = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [25:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // i_sample, q_sample
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // magnitude, z_measured, z_corrected, phase_deg
    output logic [87:0] m_axis_tdata,
    // saturated
    output logic        m_axis_tuser
);
    import iqz_pkg::*;

    localparam int W  = SAMPLE_BITS;
    localparam int XW = W + 10;
    localparam int N  = (W > CORDIC_STAGES) ? W : CORDIC_STAGES;
    localparam int PW = W + 24;

    logic [23:0] r_z_scale;
    logic [25:0] r_cal_intercept;
    logic [19:0] r_cal_inv_slope;
    logic [18:0] r_sat_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z_scale       <= Z_SCALE_RST;
            r_cal_intercept <= CAL_INTERCEPT_RST;
            r_cal_inv_slope <= CAL_INV_SLOPE_RST;
            r_sat_threshold <= SAT_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_Z_SCALE:       r_z_scale       <= i_cfg_data[23:0];
                REG_CAL_INTERCEPT: r_cal_intercept <= i_cfg_data;
                REG_CAL_INV_SLOPE: r_cal_inv_slope <= i_cfg_data[19:0];
                REG_SAT_THRESHOLD: r_sat_threshold <= i_cfg_data[18:0];
            endcase
        end
    end

    logic w_en;
    logic r5_vld;
    assign w_en          = !r5_vld || m_axis_tready;
    assign s_axis_tready = w_en;

    // stage 1: abs, flags, cordic start
    logic signed [W-1:0]     w_i, w_q;
    logic [W-1:0]            w_ai, w_aq;
    logic signed [XW-1:0]    w_xs, w_ys;
    t_ctl                    n1_ctl, r1_ctl;
    logic [W-1:0]            r1_ai, r1_aq;
    logic signed [XW-1:0]    n1_x, n1_y, r1_x, r1_y;
    logic signed [ANG_W-1:0] n1_ang, r1_ang;

    always_comb begin
        w_i  = s_axis_tdata[W-1:0];
        w_q  = s_axis_tdata[2*W-1:W];
        w_ai = w_i[W-1] ? W'(-w_i) : W'(w_i);
        w_aq = w_q[W-1] ? W'(-w_q) : W'(w_q);
        w_xs = XW'(w_i) <<< 8;
        w_ys = XW'(w_q) <<< 8;
        n1_ctl.vld  = s_axis_tvalid;
        n1_ctl.zero = (w_i == '0) && (w_q == '0);
        n1_ctl.sat  = (33'(w_ai) >= 33'(r_sat_threshold))
                   || (33'(w_aq) >= 33'(r_sat_threshold));
        if (w_i[W-1]) begin
            n1_x   = -w_xs;
            n1_y   = -w_ys;
            n1_ang = w_q[W-1] ? -ANG_180 : ANG_180;
        end else begin
            n1_x   = w_xs;
            n1_y   = w_ys;
            n1_ang = '0;
        end
    end

    // stages 2 and 3: squares, then their sum
    t_ctl                    r2_ctl, r3_ctl;
    logic [2*W-1:0]          r2_sqi, r2_sqq, r3_sum;
    logic signed [XW-1:0]    r2_x, r2_y, r3_x, r3_y;
    logic signed [ANG_W-1:0] r2_ang, r3_ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl.vld <= 1'b0;
            r2_ctl.vld <= 1'b0;
            r3_ctl.vld <= 1'b0;
        end else if (w_en) begin
            r1_ctl <= n1_ctl;
            r2_ctl <= r1_ctl;
            r3_ctl <= r2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ai  <= w_ai;
            r1_aq  <= w_aq;
            r1_x   <= n1_x;
            r1_y   <= n1_y;
            r1_ang <= n1_ang;
            r2_sqi <= (2*W)'(r1_ai) * (2*W)'(r1_ai);
            r2_sqq <= (2*W)'(r1_aq) * (2*W)'(r1_aq);
            r2_x   <= r1_x;
            r2_y   <= r1_y;
            r2_ang <= r1_ang;
            r3_sum <= r2_sqi + r2_sqq;
            r3_x   <= r2_x;
            r3_y   <= r2_y;
            r3_ang <= r2_ang;
        end
    end

    // square root and cordic stages side by side
    t_ctl                    w_ctl  [0:N];
    logic [2*W-1:0]          w_rem  [0:N];
    logic [W-1:0]            w_root [0:N];
    logic signed [XW-1:0]    w_x    [0:N];
    logic signed [XW-1:0]    w_y    [0:N];
    logic signed [ANG_W-1:0] w_ang  [0:N];

    assign w_ctl[0]  = r3_ctl;
    assign w_rem[0]  = r3_sum;
    assign w_root[0] = '0;
    assign w_x[0]    = r3_x;
    assign w_y[0]    = r3_y;
    assign w_ang[0]  = r3_ang;

    generate
        for (genvar k = 0; k < N; k++) begin : g_stage
            iqz_stage #(
                .W         (W),
                .XW        (XW),
                .K         (k),
                .J         ((k < W) ? (W - 1 - k) : 0),
                .DO_SQRT   (k < W),
                .DO_CORDIC (k < CORDIC_STAGES)
            ) u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_ctl   (w_ctl[k]),
                .i_rem   (w_rem[k]),
                .i_root  (w_root[k]),
                .i_x     (w_x[k]),
                .i_y     (w_y[k]),
                .i_ang   (w_ang[k]),
                .o_ctl   (w_ctl[k+1]),
                .o_rem   (w_rem[k+1]),
                .o_root  (w_root[k+1]),
                .o_x     (w_x[k+1]),
                .o_y     (w_y[k+1]),
                .o_ang   (w_ang[k+1])
            );
        end
    endgenerate

    // post stages: scale, saturate, calibrate
    t_ctl                    r_p1_ctl, r_p2_ctl, r_p3_ctl, r_p4_ctl;
    logic                    r5_sat;
    logic [W-1:0]            r_p1_mag, r_p2_mag, r_p3_mag, r_p4_mag, r5_mag;
    logic signed [16:0]      n_ph, r_p1_ph, r_p2_ph, r_p3_ph, r_p4_ph, r5_ph;
    logic [PW-1:0]           r_p1_zp;
    logic [24:0]             n_zm, r_p2_zm, r_p3_zm, r_p4_zm, r5_zm;
    logic signed [26:0]      r_p3_diff;
    logic signed [47:0]      r_p4_prod;
    logic signed [25:0]      n_zc, r5_zc;
    logic signed [ANG_W-1:0] w_rnd;
    logic [PW-1:0]           w_zsh;
    logic signed [31:0]      w_zc32;

    always_comb begin
        w_rnd = (w_ang[N] + ANG_W'(128)) >>> 8;
        if (w_ctl[N].zero) begin
            n_ph = '0;
        end else if (w_rnd > ANG_W'(PH_LIM)) begin
            n_ph = PH_LIM;
        end else if (w_rnd < -ANG_W'(PH_LIM)) begin
            n_ph = -PH_LIM;
        end else begin
            n_ph = w_rnd[16:0];
        end
        w_zsh = r_p1_zp >> 16;
        n_zm  = (64'(w_zsh) > 64'(ZM_MAX)) ? ZM_MAX : w_zsh[24:0];
        w_zc32 = 32'(r_p4_prod >>> 16);
        if (w_zc32 > 32'sd33554431) begin
            n_zc = 26'sd33554431;
        end else if (w_zc32 < -32'sd33554432) begin
            n_zc = -26'sd33554432;
        end else begin
            n_zc = w_zc32[25:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_ctl.vld <= 1'b0;
            r_p2_ctl.vld <= 1'b0;
            r_p3_ctl.vld <= 1'b0;
            r_p4_ctl.vld <= 1'b0;
            r5_vld       <= 1'b0;
        end else if (w_en) begin
            r_p1_ctl <= w_ctl[N];
            r_p2_ctl <= r_p1_ctl;
            r_p3_ctl <= r_p2_ctl;
            r_p4_ctl <= r_p3_ctl;
            r5_vld   <= r_p4_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_mag  <= w_root[N];
            r_p1_ph   <= n_ph;
            r_p1_zp   <= PW'(w_root[N]) * PW'(r_z_scale);
            r_p2_mag  <= r_p1_mag;
            r_p2_ph   <= r_p1_ph;
            r_p2_zm   <= n_zm;
            r_p3_mag  <= r_p2_mag;
            r_p3_ph   <= r_p2_ph;
            r_p3_zm   <= r_p2_zm;
            r_p3_diff <= $signed({2'b00, r_p2_zm}) - 27'($signed(r_cal_intercept));
            r_p4_mag  <= r_p3_mag;
            r_p4_ph   <= r_p3_ph;
            r_p4_zm   <= r_p3_zm;
            r_p4_prod <= 48'(r_p3_diff) * 48'($signed({1'b0, r_cal_inv_slope}));
            r5_mag    <= r_p4_mag;
            r5_ph     <= r_p4_ph;
            r5_zm     <= r_p4_zm;
            r5_zc     <= n_zc;
            r5_sat    <= r_p4_ctl.sat;
        end
    end

    assign m_axis_tvalid = r5_vld;
    assign m_axis_tdata  = {r5_ph, r5_zc, r5_zm, 20'(r5_mag)};
    assign m_axis_tuser  = r5_sat;

endmodule

// ===== design/iqz_checker.sv =====
`include "assert_macros.svh"

module iqz_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    `ASSERT_ON(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output word dropped while stalled")
    `ASSERT_ON(a_out_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser), "output word changed while stalled")
    `ASSERT_ON(a_ready, i_clk, i_rst_n, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not follow output space")
    `ASSERT_ON(a_phase, i_clk, i_rst_n, m_axis_tvalid |-> ($signed(m_axis_tdata[87:71]) <= 17'sd46080) && ($signed(m_axis_tdata[87:71]) >= -17'sd46080), "phase out of range")
    `ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind iq_to_impedance_phase_top iqz_checker u_iqz_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/sv/tb_iq_to_impedance_phase_top.sv =====
`timescale 1ns / 1ps

module tb_iq_to_impedance_phase_top;
    import iqz_pkg::*;

    typedef struct packed {
        logic signed [16:0] ph;
        logic signed [25:0] zc;
        logic [24:0]        zm;
        logic [19:0]        mag;
        logic               sat;
    } t_imp;

    typedef struct {
        int    i_s;
        int    q_s;
        bit    typed;
        t_imp  res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [25:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic        m_axis_tuser;

    iq_to_impedance_phase_top i_dut (.*);

    always #5 i_clk = ~i_clk;

    // register copies
    longint z_scale_r, icpt_r, slope_r, thr_r;

    t_imp   pending_imp[$];
    bit     use_typed = 1'b0;
    t_imp   typed_res;
    int     words_in = 0;
    int     errors = 0;
    bit     calm = 1'b0;
    bit     held = 1'b0;

    longint atan_step [23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                               29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                               29, 14, 7, 4, 2, 1};

    function automatic longint root_floor(longint n);
        longint res, b;
        res = 0;
        b = longint'(1) << 40;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_imp calc_impedance(longint i_s, longint q_s);
        t_imp r;
        longint ai, aq, mag, zm, diff, zc, x, y, ang, dx, dy, ph, icpt;
        ai = (i_s < 0) ? -i_s : i_s;
        aq = (q_s < 0) ? -q_s : q_s;
        mag = root_floor(ai * ai + aq * aq);
        zm = (mag * z_scale_r) >>> 16;
        if (zm > 33554431) zm = 33554431;
        icpt = (icpt_r >= 33554432) ? icpt_r - 67108864 : icpt_r;
        diff = zm - icpt;
        zc = (diff * slope_r) >>> 16;
        if (zc > 33554431) zc = 33554431;
        if (zc < -33554432) zc = -33554432;
        ph = 0;
        if (i_s != 0 || q_s != 0) begin
            x = i_s * 256;
            y = q_s * 256;
            ang = 0;
            if (x < 0) begin
                ang = (q_s >= 0) ? 180 * 65536 : -180 * 65536;
                x = -x;
                y = -y;
            end
            for (int k = 0; k < 20; k++) begin
                dx = y >>> k;
                dy = x >>> k;
                if (y > 0) begin
                    x = x + dx; y = y - dy; ang = ang + atan_step[k];
                end else begin
                    x = x - dx; y = y + dy; ang = ang - atan_step[k];
                end
            end
            ph = (ang + 128) >>> 8;
            if (ph > 46080) ph = 46080;
            if (ph < -46080) ph = -46080;
        end
        r.mag = mag[19:0];
        r.zm  = zm[24:0];
        r.zc  = zc[25:0];
        r.ph  = ph[16:0];
        r.sat = (ai >= thr_r) || (aq >= thr_r);
        return r;
    endfunction

    // input side: predict on every accepted word
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            if (use_typed)
                pending_imp.push_back(typed_res);
            else
                pending_imp.push_back(calc_impedance(
                    longint'($signed(s_axis_tdata[19:0])),
                    longint'($signed(s_axis_tdata[39:20]))));
            words_in++;
        end
    end

    // output side
    always @(posedge i_clk) begin
        t_imp got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata, m_axis_tuser};
            if (pending_imp.size() == 0) begin
                $display("%0t unexpected word: got %h", $time, got);
                errors++;
            end else begin
                want = pending_imp.pop_front();
                if (got.mag !== want.mag) begin
                    $display("%0t magnitude exp %0d got %0d", $time, want.mag, got.mag);
                    errors++;
                end
                if (got.zm !== want.zm) begin
                    $display("%0t z_measured exp %0d got %0d", $time, want.zm, got.zm);
                    errors++;
                end
                if (got.zc !== want.zc) begin
                    $display("%0t z_corrected exp %0d got %0d", $time, want.zc, got.zc);
                    errors++;
                end
                if (got.ph !== want.ph) begin
                    $display("%0t phase_deg exp %0d got %0d", $time, want.ph, got.ph);
                    errors++;
                end
                if (got.sat !== want.sat) begin
                    $display("%0t saturated exp %0d got %0d", $time, want.sat, got.sat);
                    errors++;
                end
            end
        end
    end

    // receiver with random stalls and one long hold-off
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && words_in >= 500) begin
                held = 1'b1;
                m_axis_tready = 1'b0;
                repeat (300) @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [25:0] val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_Z_SCALE:       z_scale_r = val[23:0];
            REG_CAL_INTERCEPT: icpt_r    = val[25:0];
            REG_CAL_INV_SLOPE: slope_r   = val[19:0];
            REG_SAT_THRESHOLD: thr_r     = val[18:0];
        endcase
    endtask

    task automatic set_regs(logic [25:0] zs, logic [25:0] ic, logic [25:0] sl, logic [25:0] th);
        write_reg(REG_Z_SCALE, zs);
        write_reg(REG_CAL_INTERCEPT, ic);
        write_reg(REG_CAL_INV_SLOPE, sl);
        write_reg(REG_SAT_THRESHOLD, th);
    endtask

    task automatic send_sample(int i_s, int q_s);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {q_s[19:0], i_s[19:0]};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain;
        s_axis_tvalid = 1'b0;
        use_typed = 1'b0;
        while (pending_imp.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    function automatic int rand_sample();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 40) - 20;
            1: return $urandom_range(0, 1) ? 524287 - $urandom_range(0, 20000)
                                           : -524288 + $urandom_range(0, 20000);
            default: return $urandom_range(0, 1048575) - 524288;
        endcase
    endfunction

    t_row dir_rows [$];

    initial begin
        t_row row;
        t_imp zero_res;
        z_scale_r = Z_SCALE_RST;
        icpt_r    = CAL_INTERCEPT_RST;
        slope_r   = CAL_INV_SLOPE_RST;
        thr_r     = SAT_THRESHOLD_RST;
        zero_res = '0;
        dir_rows = '{
            '{0, 0, 1'b1, zero_res},
            '{524287, 0, 1'b0, zero_res}, '{-524288, 0, 1'b0, zero_res},
            '{0, 524287, 1'b0, zero_res}, '{0, -524288, 1'b0, zero_res},
            '{524287, 524287, 1'b0, zero_res}, '{-524288, -524288, 1'b0, zero_res},
            '{-524288, 524287, 1'b0, zero_res}, '{524287, -524288, 1'b0, zero_res},
            '{507900, 0, 1'b0, zero_res}, '{507899, 0, 1'b0, zero_res},
            '{0, -507900, 1'b0, zero_res}, '{0, -507899, 1'b0, zero_res},
            '{1, 0, 1'b0, zero_res}, '{-1, 0, 1'b0, zero_res},
            '{0, 1, 1'b0, zero_res}, '{0, -1, 1'b0, zero_res},
            '{-1, -1, 1'b0, zero_res}, '{-5, 0, 1'b0, zero_res},
            '{3, 4, 1'b0, zero_res}, '{-300000, 400000, 1'b0, zero_res}
        };
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[n]) begin
            row = dir_rows[n];
            use_typed = row.typed;
            typed_res = row.res;
            send_sample(row.i_s, row.q_s);
        end
        drain();

        // extreme register settings, threshold zero flags everything
        set_regs(26'd16777215, 26'h2000000, 26'd1048575, 26'd0);
        foreach (dir_rows[n]) send_sample(dir_rows[n].i_s, dir_rows[n].q_s);
        drain();
        set_regs(26'd1, 26'h1FFFFFF, 26'd1, 26'd524287);
        foreach (dir_rows[n]) send_sample(dir_rows[n].i_s, dir_rows[n].q_s);
        drain();
        // zero scale and zero slope multiply by zero
        set_regs(26'd0, $urandom_range(0, 67108863), 26'd0, $urandom_range(0, 524287));
        for (int n = 0; n < 40; n++) send_sample(rand_sample(), rand_sample());
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 7) calm = 1'b1;
            set_regs($urandom_range(0, 67108863), $urandom_range(0, 67108863),
                     $urandom_range(0, 67108863), $urandom_range(0, 67108863));
            for (int n = 0; n < 190; n++) send_sample(rand_sample(), rand_sample());
            drain();
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
